/* src/plid_pkg.sv */
package plid_pkg;

  localparam int unsigned DataW      = 32;
  localparam int unsigned PosW       = 7;
  localparam int unsigned FillW      = 8;
  localparam int unsigned FuncW      = 3;
  localparam int unsigned StatusW    = 2;
  localparam int unsigned DepthDflt  = 128;

  typedef enum logic [FuncW-1:0] {
    OP_APPEND = 3'd0,
    OP_UPDATE = 3'd1,
    OP_INSERT = 3'd2,
    OP_DELETE = 3'd3,
    OP_READ   = 3'd4
  } func_e;

  typedef enum logic [StatusW-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  typedef struct packed {
    logic load;
    logic take_left;
    logic take_right;
  } cell_cmd_t;

endpackage

/* src/plid_if.sv */
interface plid_in_if;
  import plid_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [FuncW-1:0]      func;
  logic [PosW-1:0]       position;
  logic signed [DataW-1:0] value;

  modport source (output valid, func, position, value, input ready);
  modport sink   (input valid, func, position, value, output ready);
endinterface

interface plid_out_if;
  import plid_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [DataW-1:0] read_value;
  logic [FillW-1:0]        fill_count;
  logic [StatusW-1:0]      status;

  modport source (output valid, read_value, fill_count, status, input ready);
  modport sink   (input valid, read_value, fill_count, status, output ready);
endinterface

/* src/plid_cell.sv */
module plid_cell (
  input  logic                           clk_i,
  input  plid_pkg::cell_cmd_t            cmd_i,
  input  logic [plid_pkg::DataW-1:0]     new_i,
  input  logic [plid_pkg::DataW-1:0]     left_i,
  input  logic [plid_pkg::DataW-1:0]     right_i,
  output logic [plid_pkg::DataW-1:0]     data_o
);
  import plid_pkg::*;

  logic [DataW-1:0] data_q;
  logic [DataW-1:0] data_d;

  always_comb begin
    data_d = data_q;
    if (cmd_i.load) begin
      data_d = new_i;
    end else if (cmd_i.take_left) begin
      data_d = left_i;
    end else if (cmd_i.take_right) begin
      data_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
endmodule

/* src/positional_list_insert_delete.sv */
// Channel | Dir | Fields                              | Beat accepted
// in_i    | in  | func, position, value               | valid && ready
// out_o   | out | read_value, fill_count, status      | valid && ready
//
// One item per cycle: each cell of the row loads, shifts from a neighbor or holds
// in the cycle the item is accepted, and the result lands in the output register.
// The read path is a one-hot select across all DEPTH cells into that register.
// Reset clears the fill count and the output valid; cell contents stay undefined.
// A stalled result holds in_i.ready low until out_o takes it.
module positional_list_insert_delete #(
  parameter int unsigned DEPTH = plid_pkg::DepthDflt
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  plid_in_if.sink     in_i,
  plid_out_if.source  out_o
);
  import plid_pkg::*;

  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned CmpW = (CntW > PosW) ? CntW : PosW;

  logic [CntW-1:0]    count_q, count_d;
  logic               out_valid_q;
  logic [DataW-1:0]   read_value_q, read_value_d;
  logic [FillW-1:0]   fill_count_q;
  status_e            status_q, status_d;

  logic               accept;
  logic               full;
  logic               pos_ok;
  logic [CmpW-1:0]    pos_x, cnt_x, ins_x;
  logic [DataW-1:0]   cell_data [DEPTH];
  cell_cmd_t          cell_cmd  [DEPTH];
  logic [DataW-1:0]   sel_data;
  func_e              func;

  assign func     = func_e'(in_i.func);
  assign accept   = in_i.valid && in_i.ready;
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign full     = (count_q == CntW'(DEPTH));
  assign pos_x    = CmpW'(in_i.position);
  assign cnt_x    = CmpW'(count_q);
  assign pos_ok   = pos_x < cnt_x;
  assign ins_x    = (pos_x > cnt_x) ? cnt_x : pos_x;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam logic [CmpW-1:0] Idx = CmpW'(i);
    logic [DataW-1:0] left, right;

    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid_l
      assign left = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right = '0;
    end else begin : g_mid_r
      assign right = cell_data[i+1];
    end

    always_comb begin
      cell_cmd[i] = '0;
      if (accept) begin
        case (func)
          OP_APPEND: cell_cmd[i].load = !full && (Idx == cnt_x);
          OP_UPDATE: cell_cmd[i].load = pos_ok && (Idx == pos_x);
          OP_INSERT: begin
            cell_cmd[i].load      = !full && (Idx == ins_x);
            cell_cmd[i].take_left = !full && (Idx > ins_x) && (Idx <= cnt_x);
          end
          OP_DELETE: cell_cmd[i].take_right = pos_ok && (Idx >= pos_x);
          default: cell_cmd[i] = '0;
        endcase
      end
    end

    plid_cell u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cell_cmd[i]),
      .new_i   (in_i.value),
      .left_i  (left),
      .right_i (right),
      .data_o  (cell_data[i])
    );
  end

  always_comb begin
    sel_data = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (CmpW'(i) == pos_x) begin
        sel_data = sel_data | cell_data[i];
      end
    end
  end

  always_comb begin
    count_d      = count_q;
    status_d     = ST_DONE;
    read_value_d = '0;
    case (func)
      OP_APPEND, OP_INSERT: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          count_d = count_q + CntW'(1);
        end
      end
      OP_UPDATE: begin
        if (!pos_ok) begin
          status_d = ST_RANGE;
        end
      end
      OP_DELETE: begin
        if (!pos_ok) begin
          status_d = ST_RANGE;
        end else begin
          count_d = count_q - CntW'(1);
        end
      end
      OP_READ: begin
        if (!pos_ok) begin
          status_d = ST_RANGE;
        end else begin
          read_value_d = sel_data;
        end
      end
      default: status_d = ST_DONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      read_value_q <= read_value_d;
      fill_count_q <= FillW'(count_d);
      status_q     <= status_d;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.read_value = read_value_q;
  assign out_o.fill_count = fill_count_q;
  assign out_o.status     = status_q;

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(DEPTH))
    else $error("fill count beyond depth");

  a_accept_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_q)
    else $error("accepted beat gave no result");

  a_full_reject : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && full && (func == OP_APPEND || func == OP_INSERT))
      |=> (status_q == ST_FULL) && $stable(count_q))
    else $error("full list not rejected");

  a_range_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !pos_ok && (func == OP_DELETE || func == OP_UPDATE || func == OP_READ))
      |=> (status_q == ST_RANGE) && $stable(count_q) && (read_value_q == '0))
    else $error("out-of-range position not rejected");
endmodule

/* verif/positional_list_insert_delete_test.sv */
module positional_list_insert_delete_test;
  timeunit 1ns;
  timeprecision 1ps;

  import plid_pkg::*;

  typedef struct packed {
    logic [DataW-1:0]   rd;
    logic [FillW-1:0]   fill;
    logic [StatusW-1:0] st;
  } list_result_t;

  typedef enum int {GROW, SHRINK, CHURN} mix_e;

  class list_board;
    logic [DataW-1:0] cells [DepthDflt];
    int               fill;
    int               errors;
    list_result_t     pending [$];

    function new();
      fill   = 0;
      errors = 0;
    endfunction

    function void note_beat(logic [FuncW-1:0] f, logic [PosW-1:0] pos,
                            logic [DataW-1:0] val);
      list_result_t r;
      int           p;
      r.rd = '0;
      r.st = ST_DONE;
      p    = pos;
      case (f)
        OP_APPEND: begin
          if (fill >= DepthDflt) begin
            r.st = ST_FULL;
          end else begin
            cells[fill] = val;
            fill++;
          end
        end
        OP_UPDATE: begin
          if (p >= fill) r.st = ST_RANGE;
          else cells[p] = val;
        end
        OP_INSERT: begin
          if (fill >= DepthDflt) begin
            r.st = ST_FULL;
          end else begin
            if (p > fill) p = fill;
            for (int i = fill; i > p; i--) cells[i] = cells[i-1];
            cells[p] = val;
            fill++;
          end
        end
        OP_DELETE: begin
          if (p >= fill) begin
            r.st = ST_RANGE;
          end else begin
            for (int i = p; i + 1 < fill; i++) cells[i] = cells[i+1];
            fill--;
          end
        end
        OP_READ: begin
          if (p >= fill) r.st = ST_RANGE;
          else r.rd = cells[p];
        end
        default: ;
      endcase
      r.fill = FillW'(fill);
      pending.push_back(r);
    endfunction

    function void check_beat(list_result_t seen);
      list_result_t want;
      if (pending.size() == 0) begin
        $display("%0t: expected none, actual rd=%h fill=%0d status=%0d",
                 $time, seen.rd, seen.fill, seen.st);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (seen !== want) begin
        $display("%0t: expected rd=%h fill=%0d status=%0d, actual rd=%h fill=%0d status=%0d",
                 $time, want.rd, want.fill, want.st, seen.rd, seen.fill, seen.st);
        errors++;
      end
    endfunction
  endclass

  logic      clk_i  = 1'b0;
  logic      rst_ni = 1'b0;
  logic      idle_on;
  int        hold_ticket = 0;
  int        quiet_cycles = 0;
  list_board board;

  plid_in_if  in_if ();
  plid_out_if out_if ();

  positional_list_insert_delete DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        board.note_beat(in_if.func, in_if.position, in_if.value);
      end
      if (out_if.valid && out_if.ready) begin
        board.check_beat({out_if.read_value, out_if.fill_count, out_if.status});
      end
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= 2000) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Result side: random idles plus long hold-offs requested by ticket.
  initial begin
    int seen_ticket;
    int hold_left;
    seen_ticket = 0;
    hold_left   = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_ticket != seen_ticket) begin
        seen_ticket = hold_ticket;
        hold_left   = 100;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= !(idle_on && $urandom_range(99) < 6);
      end
    end
  end

  task automatic send_beat(input logic [FuncW-1:0] f, input logic [PosW-1:0] pos,
                           input logic [DataW-1:0] val);
    while (idle_on && $urandom_range(99) < 6) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid    <= 1'b1;
    in_if.func     <= f;
    in_if.position <= pos;
    in_if.value    <= val;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
  endtask

  task automatic run_mix(input mix_e mix, input int n, input int hold_at);
    logic [FuncW-1:0] f;
    logic [PosW-1:0]  pos;
    logic [DataW-1:0] val;
    int               roll;
    int               span;
    for (int k = 0; k < n; k++) begin
      if (k == hold_at) hold_ticket <= hold_ticket + 1;
      roll = $urandom_range(99);
      case (mix)
        GROW:   f = roll < 35 ? OP_APPEND : roll < 70 ? OP_INSERT : roll < 78 ? OP_UPDATE :
                    roll < 90 ? OP_READ : roll < 95 ? OP_DELETE : FuncW'($urandom_range(5, 7));
        SHRINK: f = roll < 60 ? OP_DELETE : roll < 78 ? OP_READ : roll < 86 ? OP_UPDATE :
                    roll < 90 ? OP_APPEND : roll < 95 ? OP_INSERT : FuncW'($urandom_range(5, 7));
        default: f = roll < 20 ? OP_APPEND : roll < 40 ? OP_INSERT : roll < 55 ? OP_UPDATE :
                     roll < 75 ? OP_READ : roll < 95 ? OP_DELETE : FuncW'($urandom_range(5, 7));
      endcase
      span = (board.fill > 127) ? 127 : board.fill;
      pos  = ($urandom_range(99) < 75) ? PosW'($urandom_range(span)) : PosW'($urandom());
      roll = $urandom_range(99);
      val  = roll < 3 ? 32'h7fff_ffff : roll < 6 ? 32'h8000_0000 : roll < 8 ? '0 :
             roll < 10 ? '1 : DataW'($urandom());
      send_beat(f, pos, val);
    end
  endtask

  initial begin
    board = new();
    idle_on        <= 1'b1;
    in_if.valid    <= 1'b0;
    in_if.func     <= OP_READ;
    in_if.position <= '0;
    in_if.value    <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_beat(OP_READ,   7'd0,   32'h0);
    send_beat(OP_UPDATE, 7'd0,   32'h1234_5678);
    send_beat(OP_DELETE, 7'd5,   32'h0);
    send_beat(OP_INSERT, 7'd127, 32'h7fff_ffff);
    send_beat(OP_APPEND, 7'd0,   32'h8000_0000);
    send_beat(OP_INSERT, 7'd0,   32'hffff_ffff);
    send_beat(OP_INSERT, 7'd1,   32'h0);
    send_beat(OP_READ,   7'd0,   32'h0);
    send_beat(OP_READ,   7'd1,   32'h0);
    send_beat(OP_READ,   7'd2,   32'h0);
    send_beat(OP_READ,   7'd3,   32'h0);
    send_beat(OP_READ,   7'd4,   32'h0);
    send_beat(OP_UPDATE, 7'd2,   32'h5555_5555);
    send_beat(OP_READ,   7'd2,   32'h0);
    send_beat(OP_DELETE, 7'd0,   32'h0);
    send_beat(OP_DELETE, 7'd2,   32'h0);
    send_beat(3'd5,      7'd0,   32'hdead_beef);
    send_beat(3'd6,      7'd1,   32'h0);
    send_beat(3'd7,      7'd127, 32'hffff_ffff);
    send_beat(OP_READ,   7'd127, 32'h0);
    send_beat(OP_UPDATE, 7'd127, 32'h1);
    send_beat(OP_APPEND, 7'd0,   32'haaaa_aaaa);
    send_beat(OP_INSERT, 7'd1,   32'h0f0f_0f0f);
    send_beat(OP_READ,   7'd1,   32'h0);
    send_beat(OP_READ,   7'd3,   32'h0);

    run_mix(GROW, 260, 120);
    run_mix(SHRINK, 260, -1);
    idle_on <= 1'b0;
    run_mix(CHURN, 200, -1);
    idle_on <= 1'b1;
    run_mix(GROW, 260, 50);
    run_mix(SHRINK, 270, -1);
    in_if.valid <= 1'b0;

    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
